/* src/qii_pkg.sv */
// Shared widths, register indexes and reset values for the inverse interpolation block.
package qii_pkg;
	localparam int IO_W   = 32;          // sample, target and result width
	localparam int WW     = 56;          // working width of the Newton terms
	localparam int NW     = 32;          // offset n, signed Q8.24
	localparam int QB     = 24;          // fraction bits of n and of the step
	localparam int DW     = 52;          // divider operand width
	localparam int TOL_W  = 25;
	localparam int ITER_W = 8;
	localparam int CFG_W  = 25;

	localparam logic [TOL_W-1:0]  N_ONE         = TOL_W'(1) << QB;
	localparam logic [TOL_W-1:0]  TOL_RESET     = TOL_W'(16777);
	localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(100);

	typedef enum logic {
		REG_TOLERANCE = 1'b0,
		REG_MAX_ITER  = 1'b1
	} cfg_reg_t;
endpackage

/* src/quadratic_inverse_interpolation.sv */
// Top level: Newton search for the target crossing of a three-point parabola.
//
//  channel   signals                                        direction
//  input     in_valid/in_ready, x_first..target_y           in
//  result    out_valid/out_ready, x_found                   out
//  config    cfg_we, cfg_index, cfg_data                    in
//
// One item runs k Newton steps (k <= max_iterations). Each step runs two serial
// multiplies on n and, unless the step clamps or its denominator is zero, a serial
// divide; the closing multiply gives x_found.
// Reset clears the FSM and loads tolerance 16777 and max_iterations 100.
// The next item is taken once the previous result sits in the output register;
// a stalled result only holds the final write.
module quadratic_inverse_interpolation import qii_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [IO_W-1:0] x_first,
	input  logic signed [IO_W-1:0] x_center,
	input  logic signed [IO_W-1:0] y_first,
	input  logic signed [IO_W-1:0] y_middle,
	input  logic signed [IO_W-1:0] y_last,
	input  logic signed [IO_W-1:0] target_y,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [IO_W-1:0] x_found,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_UPD,
		ST_FMUL
	} state_t;

	state_t state_q;

	logic [TOL_W-1:0]  tol_q;
	logic [ITER_W-1:0] max_q;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;
	logic signed [IO_W-1:0] x_found_q;

	logic signed [WW-1:0] a_q, b_q, c_q, dy_q, x1_q, dx_q, den_q, mv_q;
	logic signed [NW-1:0] n_q;
	logic [TOL_W-1:0]     mag_q;
	logic                 neg_q;
	logic                 mul_start_q, div_start_q;
	logic [DW-1:0]        un_q, ud_q;

	logic                 mul_busy, div_busy;
	logic signed [WW-1:0] mul_prod;
	logic [QB-1:0]        div_mag;
	logic                 mul_idle, div_idle;

	function automatic logic signed [WW-1:0] sx(input logic signed [IO_W-1:0] x);
		return {{(WW-IO_W){x[IO_W-1]}}, x};
	endfunction

	qii_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start_q),
		.v     (mv_q),
		.m     (n_q),
		.busy  (mul_busy),
		.prod  (mul_prod)
	);

	qii_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.un    (un_q),
		.ud    (ud_q),
		.busy  (div_busy),
		.mag   (div_mag)
	);

	assign mul_idle = !mul_busy && !mul_start_q;
	assign div_idle = !div_busy && !div_start_q;

	// input decode
	logic signed [WW-1:0] in_a, in_b, in_dx;
	assign in_a  = sx(y_middle) - sx(y_first);
	assign in_b  = sx(y_last) - sx(y_middle);
	assign in_dx = sx(x_center) - sx(x_first);

	logic in_xfer;
	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// first-multiply results
	logic signed [WW-1:0] t2_d, den_d;
	assign t2_d  = a_q + b_q + mul_prod;
	assign den_d = mul_prod + t2_d;

	// second-multiply results and step selection
	logic signed [WW-1:0] num_d, num_abs, den_abs;
	logic                 den_zero, clamp, neg_d;
	assign num_d    = dy_q + mul_prod;
	assign num_abs  = num_d[WW-1] ? -num_d : num_d;
	assign den_abs  = den_q[WW-1] ? -den_q : den_q;
	assign den_zero = (den_q == '0);
	assign clamp    = (num_abs >= den_abs);
	assign neg_d    = den_zero ? (!num_d[WW-1] && num_d != '0)
	                           : (num_d[WW-1] == den_q[WW-1]);

	// offset update with saturation
	logic signed [NW:0]   n_sum;
	logic signed [NW-1:0] n_new;
	logic [NW:0]          mag_ext;
	logic                 stop;
	assign mag_ext = (NW+1)'(mag_q);
	assign n_sum   = neg_q ? ({n_q[NW-1], n_q} - mag_ext) : ({n_q[NW-1], n_q} + mag_ext);
	assign n_new   = (n_sum[NW] != n_sum[NW-1])
	                 ? (n_sum[NW] ? {1'b1, {(NW-1){1'b0}}} : {1'b0, {(NW-1){1'b1}}})
	                 : n_sum[NW-1:0];
	assign stop    = (mag_q < tol_q) || (({1'b0, iter_q} + 1'b1) >= {1'b0, max_q});

	// final sum with saturation
	logic signed [WW-1:0]   res_d;
	logic signed [IO_W-1:0] res_sat;
	assign res_d   = x1_q + mul_prod;
	assign res_sat = ((res_d[WW-1:IO_W-1] == '0) || (res_d[WW-1:IO_W-1] == '1))
	                 ? res_d[IO_W-1:0]
	                 : (res_d[WW-1] ? {1'b1, {(IO_W-1){1'b0}}} : {1'b0, {(IO_W-1){1'b1}}});

	logic fin_go;
	assign fin_go = (state_q == ST_FMUL) && mul_idle && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			tol_q       <= TOL_RESET;
			max_q       <= MAX_ITER_RESET;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_TOLERANCE: tol_q <= cfg_data[TOL_W-1:0];
					REG_MAX_ITER:  max_q <= cfg_data[ITER_W-1:0];
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						iter_q      <= '0;
						mul_start_q <= 1'b1;
						state_q     <= (max_q == '0) ? ST_FMUL : ST_MUL1;
					end
				end
				ST_MUL1: begin
					if (mul_idle) begin
						mul_start_q <= 1'b1;
						state_q     <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					if (mul_idle) begin
						if (den_zero || clamp) begin
							state_q <= ST_UPD;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_idle) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					iter_q      <= iter_q + 1'b1;
					mul_start_q <= 1'b1;
					state_q     <= stop ? ST_FMUL : ST_MUL1;
				end
				ST_FMUL: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					a_q  <= in_a;
					b_q  <= in_b;
					c_q  <= in_b - in_a;
					dy_q <= (sx(y_middle) - sx(target_y)) <<< 1;
					x1_q <= sx(x_center);
					dx_q <= in_dx;
					n_q  <= '0;
					mv_q <= (max_q == '0) ? in_dx : (in_b - in_a);
				end
			end
			ST_MUL1: begin
				if (mul_idle) begin
					den_q <= den_d;
					mv_q  <= t2_d;
				end
			end
			ST_MUL2: begin
				if (mul_idle) begin
					neg_q <= neg_d;
					un_q  <= num_abs[DW-1:0];
					ud_q  <= den_abs[DW-1:0];
					if (den_zero) begin
						mag_q <= (num_d == '0) ? '0 : N_ONE;
					end else if (clamp) begin
						mag_q <= N_ONE;
					end
				end
			end
			ST_DIV: begin
				if (div_idle) begin
					mag_q <= TOL_W'(div_mag);
				end
			end
			ST_UPD: begin
				n_q  <= n_new;
				mv_q <= stop ? dx_q : c_q;
			end
			ST_FMUL: begin
				if (fin_go) begin
					x_found_q <= res_sat;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign x_found   = x_found_q;

	a_mul_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start_q |=> mul_busy)
		else $error("multiplier did not start");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy && div_busy))
		else $error("multiplier and divider busy together");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (iter_q < max_q))
		else $error("iteration count past limit");

	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!mul_busy && !div_busy))
		else $error("input taken with a unit still busy");
endmodule

/* src/qii_mul.sv */
// Bit-serial signed multiplier: one bit of n per cycle, result floored by 2^QB.
module qii_mul import qii_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [WW-1:0] v,
	input  logic signed [NW-1:0] m,
	output logic                 busy,
	output logic signed [WW-1:0] prod
);
	localparam int AW = WW + NW;

	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] mc_q;
	logic [NW-1:0]        mr_q;
	logic [$clog2(NW)-1:0] cnt_q;
	logic                 busy_q;
	logic signed [AW-1:0] addend;
	logic                 last;

	assign addend = mr_q[0] ? mc_q : '0;
	assign last   = (cnt_q == ($clog2(NW))'(NW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// sign bit of n carries negative weight
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= {{NW{v[WW-1]}}, v};
			mr_q  <= m;
		end else if (busy_q) begin
			acc_q <= last ? (acc_q - addend) : (acc_q + addend);
			mc_q  <= mc_q <<< 1;
			mr_q  <= mr_q >> 1;
		end
	end

	assign busy = busy_q;
	assign prod = acc_q[QB +: WW];
endmodule

/* src/qii_div.sv */
// Restoring divider: one quotient bit per cycle, QB fraction bits of un/ud with un < ud.
module qii_div import qii_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] un,
	input  logic [DW-1:0] ud,
	output logic          busy,
	output logic [QB-1:0] mag
);
	logic [DW-1:0]         r_q;
	logic [DW-1:0]         d_q;
	logic [QB-1:0]         q_q;
	logic [$clog2(QB)-1:0] cnt_q;
	logic                  busy_q;
	logic [DW:0]           rs;
	logic                  ge;
	logic [DW:0]           rd;

	assign rs = {r_q, 1'b0};
	assign ge = (rs >= {1'b0, d_q});
	assign rd = rs - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ($clog2(QB))'(QB - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= un;
			d_q <= ud;
			q_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? rd[DW-1:0] : rs[DW-1:0];
			q_q <= {q_q[QB-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign mag  = q_q;
endmodule

/* tb/tb_quadratic_inverse_interpolation.sv */
// Self-checking testbench for the quadratic inverse interpolation block.
`timescale 1ns / 100ps

module tb_quadratic_inverse_interpolation;
	import qii_pkg::*;

	typedef struct {
		logic signed [IO_W-1:0] x_first;
		logic signed [IO_W-1:0] x_center;
		logic signed [IO_W-1:0] y_first;
		logic signed [IO_W-1:0] y_middle;
		logic signed [IO_W-1:0] y_last;
		logic signed [IO_W-1:0] target_y;
	} sample_set_t;

	localparam longint ONE_Q24   = 64'sd16777216;
	localparam longint S32_MAX   = 64'sd2147483647;
	localparam longint S32_MIN   = -64'sd2147483648;
	localparam int     LIMIT_CYC = 30000000;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic signed [IO_W-1:0] x_first, x_center, y_first, y_middle, y_last, target_y;
	logic                   out_valid;
	logic                   out_ready;
	logic signed [IO_W-1:0] x_found;
	logic                   cfg_we;
	logic                   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	sample_set_t            pending_sets[$];
	logic signed [IO_W-1:0] expected_x[$];
	logic [TOL_W-1:0]       tol_shadow;
	logic [ITER_W-1:0]      iter_shadow;
	int                     in_gap, out_gap, errors, cycles;
	bit                     quiet;

	quadratic_inverse_interpolation DUT (.*);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// floor(v * n / 2^24), split so partial products stay small
	function automatic longint scale_by_offset(longint v, longint n);
		longint nh, nl, fr;
		nh = n >>> 24;
		nl = n - nh * ONE_Q24;
		fr = (v * (nl >>> 12) + ((v * (nl & 64'sd4095)) >>> 12)) >>> 12;
		return v * nh + fr;
	endfunction

	function automatic longint newton_correction(longint num, longint den);
		bit neg;
		longint unsigned un, ud, mag, r;
		if (den == 0) begin
			if (num > 0) return -ONE_Q24;
			if (num < 0) return ONE_Q24;
			return 0;
		end
		neg = ((num < 0) == (den < 0));
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		if (un >= ud) begin
			mag = ONE_Q24;
		end else begin
			r = un;
			mag = 0;
			for (int i = 0; i < QB; i++) begin
				r = r << 1;
				mag = mag << 1;
				if (r >= ud) begin
					r = r - ud;
					mag = mag | 1;
				end
			end
		end
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic signed [IO_W-1:0] crossing_abscissa(sample_set_t s);
		longint x0, x1, tg, y0, y1, y2, a, b, c, n, t1, t2, num, den, st, mag, res;
		int k;
		x0 = s.x_first;
		x1 = s.x_center;
		tg = s.target_y;
		y0 = longint'(s.y_first) - tg;
		y1 = longint'(s.y_middle) - tg;
		y2 = longint'(s.y_last) - tg;
		a = y1 - y0;
		b = y2 - y1;
		c = b - a;
		n = 0;
		k = 0;
		while (k < iter_shadow) begin
			t1 = scale_by_offset(c, n);
			t2 = a + b + t1;
			num = 2 * y1 + scale_by_offset(t2, n);
			den = t1 + t2;
			st = newton_correction(num, den);
			n = n + st;
			if (n > S32_MAX) n = S32_MAX;
			if (n < S32_MIN) n = S32_MIN;
			k++;
			mag = (st < 0) ? -st : st;
			if (mag < longint'(tol_shadow)) break;
		end
		res = x1 + scale_by_offset(x1 - x0, n);
		if (res > S32_MAX) res = S32_MAX;
		if (res < S32_MIN) res = S32_MIN;
		return res[IO_W-1:0];
	endfunction

	function automatic sample_set_t random_set(bit well_formed);
		sample_set_t s;
		int d, sl, cv;
		if (!well_formed) begin
			s.x_first = $urandom; s.x_center = $urandom; s.y_first = $urandom;
			s.y_middle = $urandom; s.y_last = $urandom; s.target_y = $urandom;
			return s;
		end
		d  = $urandom_range(1, 1 << 20);
		if ($urandom_range(0, 1)) d = -d;
		sl = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		cv = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		s.x_first  = $signed($urandom_range(0, 1 << 28)) - (1 << 27);
		s.x_center = s.x_first + d;
		s.target_y = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
		// crossing usually near the middle sample
		s.y_middle = s.target_y + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		s.y_first  = s.y_middle - sl + cv;
		s.y_last   = s.y_middle + sl + cv;
		return s;
	endfunction

	function automatic sample_set_t make_set(int x0, int x1, int y0, int y1, int y2, int t);
		sample_set_t s;
		s.x_first = x0; s.x_center = x1; s.y_first = y0;
		s.y_middle = y1; s.y_last = y2; s.target_y = t;
		return s;
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_x.push_back(crossing_abscissa('{x_first, x_center, y_first,
					y_middle, y_last, target_y}));
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_sets.size() > 0) begin
					sample_set_t s;
					s = pending_sets.pop_front();
					x_first <= s.x_first; x_center <= s.x_center; y_first <= s.y_first;
					y_middle <= s.y_middle; y_last <= s.y_last; target_y <= s.target_y;
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 18);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_x.size() == 0) begin
					$error("x_found transfer with nothing expected: got %0d", x_found);
					errors++;
				end else begin
					logic signed [IO_W-1:0] want;
					want = expected_x.pop_front();
					if (x_found !== want) begin
						$error("x_found expected %0d actual %0d", want, x_found);
						errors++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 18);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYC) begin
			$display("quadratic_inverse_interpolation test failed");
			$finish;
		end
	end

	task automatic drain();
		do @(negedge clk);
		while (pending_sets.size() > 0 || in_valid || expected_x.size() > 0);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TOLERANCE) tol_shadow = val[TOL_W-1:0];
		else iter_shadow = val[ITER_W-1:0];
	endtask

	task automatic run_phase(logic [CFG_W-1:0] tol, logic [CFG_W-1:0] iters, int count);
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_MAX_ITER, iters);
		for (int i = 0; i < count; i++)
			pending_sets.push_back(random_set($urandom_range(0, 4) != 0));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		x_first = '0; x_center = '0; y_first = '0; y_middle = '0; y_last = '0;
		target_y = '0; cfg_we = 1'b0; cfg_index = REG_TOLERANCE; cfg_data = '0;
		in_gap = 0; out_gap = 0; errors = 0; cycles = 0; quiet = 0;
		tol_shadow = TOL_RESET;
		iter_shadow = MAX_ITER_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: linear, flat (zero denominator), extremes, saturation
		pending_sets.push_back(make_set(0, 65536, -65536, 0, 65536, 32768));
		pending_sets.push_back(make_set(0, 65536, 100, 100, 100, 100));
		pending_sets.push_back(make_set(0, 65536, 100, 100, 100, 0));
		pending_sets.push_back(make_set(0, 65536, 100, 100, 100, 200));
		pending_sets.push_back(make_set(0, 65536, 65536, 0, 65536, -65536));
		pending_sets.push_back(make_set(0, 65536, 65536, 0, 65536, 16384));
		pending_sets.push_back(make_set(-2147483648, 2147483647, -2147483648, 0,
			2147483647, 2147483647));
		pending_sets.push_back(make_set(2147483647, -2147483648, 2147483647,
			-2147483648, 2147483647, -2147483648));
		pending_sets.push_back(make_set(-1, -1, -1, -1, -1, -1));
		pending_sets.push_back(make_set(0, 0, 0, 0, 0, 0));
		pending_sets.push_back(make_set(0, 1 << 30, 0, 1, 2, 1 << 30));
		pending_sets.push_back(make_set(1 << 30, 0, 2, 1, 0, -(1 << 30)));
		drain();

		run_phase(TOL_RESET, MAX_ITER_RESET, 55);
		run_phase(1, 255, 10);
		run_phase(N_ONE, 1, 25);
		run_phase(0, 7, 20);
		run_phase(0, 0, 8);
		quiet = 1;
		run_phase($urandom_range(1, 1 << 20), $urandom_range(1, 40), 50);

		if (errors == 0)
			$display("quadratic_inverse_interpolation test passed");
		else
			$display("quadratic_inverse_interpolation test failed");
		$finish;
	end
endmodule

/* quadratic_inverse_interpolation.f */
src/qii_pkg.sv
src/qii_mul.sv
src/qii_div.sv
src/quadratic_inverse_interpolation.sv
tb/tb_quadratic_inverse_interpolation.sv
